// ===== rtl/bsrfe_pkg.sv =====
// ----------------------------------------------------------------------------
// bsrfe_pkg: shared types and codes of the block storage register front end
// register indexes, event codes, error codes, status and interrupt bits
// ----------------------------------------------------------------------------
package bsrfe_pkg;

  localparam int DATA_W  = 64;
  localparam int VER_W   = 32;
  localparam int COUNT_W = 9;
  localparam int PADDR_W = 5;

  // event carried by one access beat
  typedef enum logic [1:0] {
    OP_REG_READ   = 2'd0,
    OP_REG_WRITE  = 2'd1,
    OP_COMPLETE   = 2'd2,
    OP_SOFT_RESET = 2'd3
  } op_t;

  // device register map
  typedef enum logic [3:0] {
    REG_MAGIC     = 4'd0,
    REG_VERSION   = 4'd1,
    REG_FEATURES  = 4'd2,
    REG_CAPACITY  = 4'd3,
    REG_SECT_SIZE = 4'd4,
    REG_MAX_XFER  = 4'd5,
    REG_LBA       = 4'd6,
    REG_DMA       = 4'd7,
    REG_COUNT     = 4'd8,
    REG_COMMAND   = 4'd9,
    REG_STATUS    = 4'd10,
    REG_ERROR     = 4'd11,
    REG_CONTROL   = 4'd12,
    REG_IRQ_STAT  = 4'd13,
    REG_IRQ_ACK   = 4'd14
  } reg_idx_t;

  // request kinds written to the command register
  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_FLUSH = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_BUSY  = 3'd1,
    ERR_CMD   = 3'd2,
    ERR_RO    = 3'd3,
    ERR_RANGE = 3'd4,
    ERR_IO    = 3'd5,
    ERR_DMA   = 3'd6
  } err_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WRITE_PROTECT = 2'd0,
    CFG_CAPACITY      = 2'd1,
    CFG_MAGIC         = 2'd2,
    CFG_VERSION       = 2'd3
  } cfg_idx_t;

  // backend completion outcomes
  localparam logic [1:0] CPL_OK        = 2'd0;
  localparam logic [1:0] CPL_DMA_FAULT = 2'd2;

  localparam logic [1:0] BAR_MAIN   = 2'd0;
  localparam logic [3:0] ACCESS_8B  = 4'd8;

  // status bit positions (read-only flag lives at bit 4, taken from config)
  localparam int ST_READY = 0;
  localparam int ST_BUSY  = 1;
  localparam int ST_DONE  = 2;
  localparam int ST_ERROR = 3;

  localparam int IRQ_DONE = 0;
  localparam int IRQ_ERR  = 1;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               access_ok;
    logic               irq_pulse;
    logic               request_issue;
    logic [1:0]         request_kind;
    logic [DATA_W-1:0]  request_lba;
    logic [DATA_W-1:0]  request_dma_address;
    logic [COUNT_W-1:0] request_sector_count;
  } result_t;

endpackage

// ===== rtl/bsrfe_access_if.sv =====
// ----------------------------------------------------------------------------
// bsrfe_access_if: access channel of the block storage register front end
// valid/ready channel carrying one register access or device event per beat
// ----------------------------------------------------------------------------
interface bsrfe_access_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [1:0]                    bar_index;
  logic [3:0]                    reg_index;
  logic [3:0]                    access_width;
  logic [bsrfe_pkg::DATA_W-1:0]  write_data;
  logic [1:0]                    completion_error;

  modport source (
    output valid, command, bar_index, reg_index, access_width, write_data,
           completion_error,
    input  ready
  );

  modport sink (
    input  valid, command, bar_index, reg_index, access_width, write_data,
           completion_error,
    output ready
  );
endinterface

// ===== rtl/bsrfe_result_if.sv =====
// ----------------------------------------------------------------------------
// bsrfe_result_if: result channel of the block storage register front end
// valid/ready channel carrying one result beat per access beat
// ----------------------------------------------------------------------------
interface bsrfe_result_if;
  logic                          valid;
  logic                          ready;
  logic [bsrfe_pkg::DATA_W-1:0]  read_data;
  logic                          access_ok;
  logic                          irq_pulse;
  logic                          request_issue;
  logic [1:0]                    request_kind;
  logic [bsrfe_pkg::DATA_W-1:0]  request_lba;
  logic [bsrfe_pkg::DATA_W-1:0]  request_dma_address;
  logic [bsrfe_pkg::COUNT_W-1:0] request_sector_count;

  modport source (
    output valid, read_data, access_ok, irq_pulse, request_issue, request_kind,
           request_lba, request_dma_address, request_sector_count,
    input  ready
  );

  modport sink (
    input  valid, read_data, access_ok, irq_pulse, request_issue, request_kind,
           request_lba, request_dma_address, request_sector_count,
    output ready
  );
endinterface

// ===== rtl/block_storage_register_front_end.sv =====
// ----------------------------------------------------------------------------
// block_storage_register_front_end: register front end of a dma block device
// decodes register reads/writes, checks commands, issues backend requests,
// tracks busy/done/error status and interrupt reasons
// ----------------------------------------------------------------------------
//
//  channel   direction  protocol     beat
//  access    in         valid/ready  one read, write, completion or soft reset
//  result    out        valid/ready  read data, access status, irq, request
//  apb       in/out     apb, 64 bit  device config, register i at byte 8*i
//
//  - one access beat per cycle unless the result stage stalls; its result is
//    registered at acceptance, and the device state is updated at the same edge
//  - access ready stays high while the result register is empty or drained
//    in the same cycle, so a full result stage stalls the access side only
//  - rst is synchronous and active high; it resets state and config at once
//  - apb writes take setup and access cycles, pready is tied high
//
module block_storage_register_front_end #(
  parameter int MAX_TRANSFER_SECTORS = 256,
  parameter int SECTOR_BYTES         = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  bsrfe_access_if.sink                    access,
  bsrfe_result_if.source                  result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsrfe_pkg::PADDR_W-1:0]   paddr,
  input  logic [bsrfe_pkg::DATA_W-1:0]    pwdata,
  output logic [bsrfe_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int DW = bsrfe_pkg::DATA_W;

  // configuration registers
  logic                          write_protect;
  logic [DW-1:0]                 medium_sectors;
  logic [DW-1:0]                 magic_value;
  logic [bsrfe_pkg::VER_W-1:0]   version_value;

  // device state; status holds ready/busy/done/error, read-only comes from config
  logic [DW-1:0]       start_sector, start_sector_next;
  logic [DW-1:0]       memory_address, memory_address_next;
  logic [DW-1:0]       transfer_count, transfer_count_next;
  logic [3:0]          status, status_next;
  bsrfe_pkg::err_t     error_code, error_code_next;
  logic                irq_enable, irq_enable_next;
  logic [1:0]          irq_pending, irq_pending_next;

  // result stage
  logic                result_valid;
  bsrfe_pkg::result_t  res, res_next;

  logic                access_fire;
  logic                cfg_write;
  bsrfe_pkg::cfg_idx_t cfg_sel;

  // decode helpers
  logic                win_ok;
  logic                busy;
  logic                range_bad;
  logic [DW-1:0]       cap_left;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_sel   = bsrfe_pkg::cfg_idx_t'(paddr[bsrfe_pkg::PADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_protect  <= 1'b0;
      medium_sectors <= '0;
      magic_value    <= '0;
      version_value  <= bsrfe_pkg::VER_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_sel)
        bsrfe_pkg::CFG_WRITE_PROTECT: write_protect  <= pwdata[0];
        bsrfe_pkg::CFG_CAPACITY:      medium_sectors <= pwdata;
        bsrfe_pkg::CFG_MAGIC:         magic_value    <= pwdata;
        bsrfe_pkg::CFG_VERSION:       version_value  <= pwdata[bsrfe_pkg::VER_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      bsrfe_pkg::CFG_WRITE_PROTECT: prdata = {{(DW-1){1'b0}}, write_protect};
      bsrfe_pkg::CFG_CAPACITY:      prdata = medium_sectors;
      bsrfe_pkg::CFG_MAGIC:         prdata = magic_value;
      bsrfe_pkg::CFG_VERSION:       prdata = DW'(version_value);
    endcase
  end

  // ---------------------------------------------------------------------------
  // access handshake: the result register is the only buffer
  // ---------------------------------------------------------------------------
  assign access.ready = !result_valid || result.ready;
  assign access_fire  = access.valid && access.ready;

  assign win_ok = (access.bar_index == bsrfe_pkg::BAR_MAIN) &&
                  (access.access_width == bsrfe_pkg::ACCESS_8B);
  assign busy   = status[bsrfe_pkg::ST_BUSY];

  // sector range check; the wrapped difference only matters when start < capacity
  assign cap_left  = medium_sectors - start_sector;
  assign range_bad = (transfer_count == '0) ||
                     (transfer_count > DW'(MAX_TRANSFER_SECTORS)) ||
                     (start_sector >= medium_sectors) ||
                     (transfer_count > cap_left);

  // ---------------------------------------------------------------------------
  // single pass decode: next state and result of the beat on the access side
  // ---------------------------------------------------------------------------
  always_comb begin
    start_sector_next   = start_sector;
    memory_address_next = memory_address;
    transfer_count_next = transfer_count;
    status_next         = status;
    error_code_next     = error_code;
    irq_enable_next     = irq_enable;
    irq_pending_next    = irq_pending;
    res_next            = '0;

    unique case (bsrfe_pkg::op_t'(access.command))
      bsrfe_pkg::OP_REG_READ: begin
        if (win_ok) begin
          res_next.access_ok = 1'b1;
          unique case (access.reg_index)
            bsrfe_pkg::REG_MAGIC:     res_next.read_data = magic_value;
            bsrfe_pkg::REG_VERSION:   res_next.read_data = DW'(version_value);
            bsrfe_pkg::REG_FEATURES: begin
              // dma and flush always, read-only when configured
              res_next.read_data = {{(DW-3){1'b0}}, write_protect, 2'b11};
            end
            bsrfe_pkg::REG_CAPACITY:  res_next.read_data = medium_sectors;
            bsrfe_pkg::REG_SECT_SIZE: res_next.read_data = DW'(SECTOR_BYTES);
            bsrfe_pkg::REG_MAX_XFER:  res_next.read_data = DW'(MAX_TRANSFER_SECTORS);
            bsrfe_pkg::REG_LBA:       res_next.read_data = start_sector;
            bsrfe_pkg::REG_DMA:       res_next.read_data = memory_address;
            bsrfe_pkg::REG_COUNT:     res_next.read_data = transfer_count;
            bsrfe_pkg::REG_COMMAND:   res_next.read_data = '0;
            bsrfe_pkg::REG_STATUS:    res_next.read_data = {{(DW-5){1'b0}}, write_protect, status};
            bsrfe_pkg::REG_ERROR:     res_next.read_data = DW'(error_code);
            bsrfe_pkg::REG_CONTROL:   res_next.read_data = DW'(irq_enable);
            bsrfe_pkg::REG_IRQ_STAT:  res_next.read_data = DW'(irq_pending);
            bsrfe_pkg::REG_IRQ_ACK:   res_next.read_data = '0;
            default:                  res_next.access_ok = 1'b0;
          endcase
        end
      end

      bsrfe_pkg::OP_REG_WRITE: begin
        if (win_ok) begin
          res_next.access_ok = 1'b1;
          unique case (access.reg_index)
            bsrfe_pkg::REG_LBA:   start_sector_next   = access.write_data;
            bsrfe_pkg::REG_DMA:   memory_address_next = access.write_data;
            bsrfe_pkg::REG_COUNT: transfer_count_next = access.write_data;
            bsrfe_pkg::REG_COMMAND: begin
              // checks in order: busy, unknown command, read-only, range
              if (busy) begin
                error_code_next                 = bsrfe_pkg::ERR_BUSY;
                irq_pending_next[bsrfe_pkg::IRQ_ERR] = 1'b1;
                res_next.irq_pulse              = irq_enable;
              end else if ((access.write_data == '0) ||
                           (access.write_data > DW'(bsrfe_pkg::REQ_FLUSH))) begin
                status_next                     = 4'b0;
                status_next[bsrfe_pkg::ST_READY] = 1'b1;
                status_next[bsrfe_pkg::ST_ERROR] = 1'b1;
                error_code_next                 = bsrfe_pkg::ERR_CMD;
                irq_pending_next[bsrfe_pkg::IRQ_ERR] = 1'b1;
                res_next.irq_pulse              = irq_enable;
              end else if ((access.write_data[1:0] == bsrfe_pkg::REQ_WRITE) &&
                           write_protect) begin
                status_next                     = 4'b0;
                status_next[bsrfe_pkg::ST_READY] = 1'b1;
                status_next[bsrfe_pkg::ST_ERROR] = 1'b1;
                error_code_next                 = bsrfe_pkg::ERR_RO;
                irq_pending_next[bsrfe_pkg::IRQ_ERR] = 1'b1;
                res_next.irq_pulse              = irq_enable;
              end else if ((access.write_data[1:0] != bsrfe_pkg::REQ_FLUSH) &&
                           range_bad) begin
                status_next                     = 4'b0;
                status_next[bsrfe_pkg::ST_READY] = 1'b1;
                status_next[bsrfe_pkg::ST_ERROR] = 1'b1;
                error_code_next                 = bsrfe_pkg::ERR_RANGE;
                irq_pending_next[bsrfe_pkg::IRQ_ERR] = 1'b1;
                res_next.irq_pulse              = irq_enable;
              end else begin
                // hand the request to the backend and go busy
                status_next                     = 4'b0;
                status_next[bsrfe_pkg::ST_BUSY] = 1'b1;
                error_code_next                 = bsrfe_pkg::ERR_NONE;
                res_next.request_issue          = 1'b1;
                res_next.request_kind           = access.write_data[1:0];
                res_next.request_lba            = start_sector;
                res_next.request_dma_address    = memory_address;
                res_next.request_sector_count   =
                  (access.write_data[1:0] == bsrfe_pkg::REQ_FLUSH) ?
                  '0 : transfer_count[bsrfe_pkg::COUNT_W-1:0];
              end
            end
            bsrfe_pkg::REG_STATUS: begin
              // write one to clear done and error
              if (access.write_data[bsrfe_pkg::ST_DONE]) begin
                status_next[bsrfe_pkg::ST_DONE] = 1'b0;
              end
              if (access.write_data[bsrfe_pkg::ST_ERROR]) begin
                status_next[bsrfe_pkg::ST_ERROR] = 1'b0;
                error_code_next                  = bsrfe_pkg::ERR_NONE;
              end
            end
            bsrfe_pkg::REG_CONTROL: irq_enable_next = access.write_data[0];
            bsrfe_pkg::REG_IRQ_ACK: irq_pending_next = irq_pending & ~access.write_data[1:0];
            default:                res_next.access_ok = 1'b0;
          endcase
        end
      end

      bsrfe_pkg::OP_COMPLETE: begin
        // completions outside a busy phase are dropped
        if (busy) begin
          status_next                      = 4'b0;
          status_next[bsrfe_pkg::ST_READY] = 1'b1;
          res_next.irq_pulse               = irq_enable;
          if (access.completion_error == bsrfe_pkg::CPL_OK) begin
            error_code_next                       = bsrfe_pkg::ERR_NONE;
            status_next[bsrfe_pkg::ST_DONE]       = 1'b1;
            irq_pending_next[bsrfe_pkg::IRQ_DONE] = 1'b1;
          end else begin
            // any failure code other than dma counts as an i/o failure
            error_code_next = (access.completion_error == bsrfe_pkg::CPL_DMA_FAULT) ?
                              bsrfe_pkg::ERR_DMA : bsrfe_pkg::ERR_IO;
            status_next[bsrfe_pkg::ST_ERROR]      = 1'b1;
            irq_pending_next[bsrfe_pkg::IRQ_ERR]  = 1'b1;
          end
        end
      end

      bsrfe_pkg::OP_SOFT_RESET: begin
        // ignored while a request is outstanding
        if (!busy) begin
          start_sector_next                = '0;
          memory_address_next              = '0;
          transfer_count_next              = '0;
          status_next                      = 4'b0;
          status_next[bsrfe_pkg::ST_READY] = 1'b1;
          error_code_next                  = bsrfe_pkg::ERR_NONE;
          irq_enable_next                  = 1'b0;
          irq_pending_next                 = 2'b0;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // state and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      start_sector                 <= '0;
      memory_address               <= '0;
      transfer_count               <= '0;
      status                       <= 4'b0001;
      error_code                   <= bsrfe_pkg::ERR_NONE;
      irq_enable                   <= 1'b0;
      irq_pending                  <= 2'b0;
      result_valid                 <= 1'b0;
    end else begin
      if (access_fire) begin
        start_sector   <= start_sector_next;
        memory_address <= memory_address_next;
        transfer_count <= transfer_count_next;
        status         <= status_next;
        error_code     <= error_code_next;
        irq_enable     <= irq_enable_next;
        irq_pending    <= irq_pending_next;
        result_valid   <= 1'b1;
      end else if (result.ready) begin
        result_valid   <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (access_fire) begin
      res <= res_next;
    end
  end

  assign result.valid                = result_valid;
  assign result.read_data            = res.read_data;
  assign result.access_ok            = res.access_ok;
  assign result.irq_pulse            = res.irq_pulse;
  assign result.request_issue        = res.request_issue;
  assign result.request_kind         = res.request_kind;
  assign result.request_lba          = res.request_lba;
  assign result.request_dma_address  = res.request_dma_address;
  assign result.request_sector_count = res.request_sector_count;

endmodule

// ===== rtl/bsrfe_checker.sv =====
// ----------------------------------------------------------------------------
// bsrfe_checker: port-level checks of the block storage register front end
// result channel holding rules and request field consistency
// ----------------------------------------------------------------------------
module bsrfe_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [bsrfe_pkg::DATA_W-1:0]  read_data,
  input logic                          access_ok,
  input logic                          request_issue,
  input logic [1:0]                    request_kind,
  input logic [bsrfe_pkg::COUNT_W-1:0] request_sector_count
);

  // a stalled beat stays offered
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  // a stalled beat keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(read_data) && $stable(request_issue) && $stable(request_kind))
    else $error("result payload changed while stalled");

  // an issued request always comes from an accepted register write
  assert property (@(posedge clk) disable iff (rst)
    result_valid && request_issue |->
      access_ok && (request_kind != bsrfe_pkg::REQ_NONE))
    else $error("request issued without a valid command write");

  // a flush carries no sectors
  assert property (@(posedge clk) disable iff (rst)
    result_valid && request_issue && (request_kind == bsrfe_pkg::REQ_FLUSH) |->
      (request_sector_count == '0))
    else $error("flush request with nonzero sector count");

  // read data only shows up on a valid access
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (read_data != '0) |-> access_ok && !request_issue)
    else $error("read data on a rejected access");

endmodule

bind block_storage_register_front_end bsrfe_checker u_bsrfe_checker (
  .clk                  (clk),
  .rst                  (rst),
  .result_valid         (result.valid),
  .result_ready         (result.ready),
  .read_data            (result.read_data),
  .access_ok            (result.access_ok),
  .request_issue        (result.request_issue),
  .request_kind         (result.request_kind),
  .request_sector_count (result.request_sector_count)
);
